### rtl/core/rsd_pkg.sv
// shared types and constants for the rtp stream demux table
package rsd_pkg;

  localparam int SSRC_ENTRIES = 64;
  localparam int NAME_ENTRIES = 32;
  localparam int NAME_BYTES   = 8;
  localparam int OWNER_W      = 8;
  localparam int SSRC_W       = 32;
  localparam int LEN_W        = 4;
  localparam int BYTES_W      = 64;
  localparam int NAME_KEY_W   = LEN_W + BYTES_W;

  localparam logic [2:0] CMD_LOOKUP   = 3'd0;
  localparam logic [2:0] CMD_ADD_SSRC = 3'd1;
  localparam logic [2:0] CMD_ADD_MID  = 3'd2;
  localparam logic [2:0] CMD_ADD_RID  = 3'd3;
  localparam logic [2:0] CMD_REMOVE   = 3'd4;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_SSRC = 3'd1;
  localparam logic [2:0] ST_MID  = 3'd2;
  localparam logic [2:0] ST_RID  = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_CMP,
    OP_WRITE,
    OP_PURGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [SSRC_W-1:0]   key;
    logic [OWNER_W-1:0]  owner;
  } ssrc_ctl_t;

  typedef struct packed {
    cell_op_t              op;
    logic [NAME_KEY_W-1:0] key;
    logic [OWNER_W-1:0]    owner;
  } name_ctl_t;

  function automatic logic [NAME_KEY_W-1:0] name_key(input logic [LEN_W-1:0] len,
                                                     input logic [BYTES_W-1:0] bytes);
    logic [LEN_W-1:0]   l;
    logic [BYTES_W-1:0] mask;
    l = (len > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : len;
    if (l >= LEN_W'(8)) begin
      mask = '1;
    end else begin
      mask = ~({BYTES_W{1'b1}} >> ({3'd0, l[2:0]} * 6'd8));
    end
    return {l, bytes & mask};
  endfunction

endpackage

### rtl/core/rsd_ssrc_cell.sv
// one entry of the ssrc table with its free slot chain link
module rsd_ssrc_cell
  import rsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ssrc_ctl_t          ctl,
  input  logic               taken_in,
  output logic               taken_out,
  output logic               hit,
  output logic [OWNER_W-1:0] hit_owner
);

  logic               valid;
  logic [SSRC_W-1:0]  key;
  logic [OWNER_W-1:0] owner;

  assign taken_out = taken_in | ~valid;
  assign hit_owner = hit ? owner : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (ctl.op)
        OP_CMP: begin
          hit <= valid && (key == ctl.key);
        end
        OP_WRITE: begin
          if (!valid && !taken_in) begin
            valid <= 1'b1;
            key   <= ctl.key;
            owner <= ctl.owner;
          end
        end
        OP_PURGE: begin
          if (valid && owner == ctl.owner) valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/rsd_name_cell.sv
// one entry of a mid or rid table with its free slot chain link
module rsd_name_cell
  import rsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  name_ctl_t          ctl,
  input  logic               taken_in,
  output logic               taken_out,
  output logic               hit,
  output logic [OWNER_W-1:0] hit_owner
);

  logic                  valid;
  logic [NAME_KEY_W-1:0] key;
  logic [OWNER_W-1:0]    owner;

  assign taken_out = taken_in | ~valid;
  assign hit_owner = hit ? owner : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      case (ctl.op)
        OP_CMP: begin
          hit <= valid && (key == ctl.key);
        end
        OP_WRITE: begin
          if (!valid && !taken_in) begin
            valid <= 1'b1;
            key   <= ctl.key;
            owner <= ctl.owner;
          end
        end
        OP_PURGE: begin
          if (valid && owner == ctl.owner) valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/rtp_stream_demux_table_core.sv
// top level of the rtp stream demux table: command sequencer and cell rows
//
// usage: drive cmd and its operand ports and pulse start while busy is low;
// the item is taken at that edge and busy rises the next cycle. three rows of
// cells (ssrc, mid, rid) compare the keys in parallel, the hits are folded
// into one owner per row, and then the update step applies the insert,
// learn or purge. the lowest free entry of a row is found by a taken chain
// that ripples from cell to cell. done is registered from the update step,
// with found, match_owner and status valid in that same cycle only. busy
// falls when the sequencer returns from its done step to idle, so a new item
// can be taken only after the previous one has gone through the compare,
// fold, update and done steps of the sequencer.
// the receiver cannot stall: each result is shown for exactly one cycle.
// reset clears every valid bit of the three rows at once and returns the
// sequencer to idle; keys and owners are not cleared.
module rtp_stream_demux_table_core
  import rsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic [SSRC_W-1:0]  stream_ssrc,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [LEN_W-1:0]   mid_length,
  input  logic [BYTES_W-1:0] mid_bytes,
  input  logic [LEN_W-1:0]   rid_length,
  input  logic [BYTES_W-1:0] rid_bytes,
  input  logic               owner_has_mid,
  output logic               done,
  output logic               found,
  output logic [OWNER_W-1:0] match_owner,
  output logic [2:0]         status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_FOLD,
    S_EXEC,
    S_DONE
  } state_t;

  state_t                state;
  logic [2:0]            cmd_r;
  logic [SSRC_W-1:0]     ssrc_r;
  logic [OWNER_W-1:0]    owner_r;
  logic [NAME_KEY_W-1:0] mkey_r;
  logic [NAME_KEY_W-1:0] rkey_r;
  logic                  has_mid_r;

  logic                  ssrc_any, mid_any, rid_any;
  logic [OWNER_W-1:0]    ssrc_own, mid_own, rid_own;

  ssrc_ctl_t             sctl;
  name_ctl_t             mctl, rctl;

  logic [SSRC_ENTRIES:0] s_taken;
  logic [NAME_ENTRIES:0] m_taken, r_taken;
  logic [SSRC_ENTRIES-1:0] s_hit;
  logic [NAME_ENTRIES-1:0] m_hit, r_hit;
  logic [OWNER_W-1:0]    s_own [SSRC_ENTRIES];
  logic [OWNER_W-1:0]    m_own [NAME_ENTRIES];
  logic [OWNER_W-1:0]    r_own [NAME_ENTRIES];

  logic                  s_or_next, m_or_next, r_or_next;
  logic [OWNER_W-1:0]    s_own_next, m_own_next, r_own_next;

  logic                  found_next;
  logic [OWNER_W-1:0]    owner_next;
  logic [2:0]            status_next;

  logic                  s_full, m_full, r_full, m_present, r_present;

  assign s_taken[0] = 1'b0;
  assign m_taken[0] = 1'b0;
  assign r_taken[0] = 1'b0;
  assign s_full = ~s_taken[SSRC_ENTRIES];
  assign m_full = ~m_taken[NAME_ENTRIES];
  assign r_full = ~r_taken[NAME_ENTRIES];
  assign m_present = mkey_r[NAME_KEY_W-1 -: LEN_W] != '0;
  assign r_present = rkey_r[NAME_KEY_W-1 -: LEN_W] != '0;

  for (genvar i = 0; i < SSRC_ENTRIES; i++) begin : g_ssrc
    rsd_ssrc_cell u_cell (
      .clk(clk), .rst(rst), .ctl(sctl),
      .taken_in(s_taken[i]), .taken_out(s_taken[i+1]),
      .hit(s_hit[i]), .hit_owner(s_own[i])
    );
  end

  for (genvar i = 0; i < NAME_ENTRIES; i++) begin : g_name
    rsd_name_cell u_mid (
      .clk(clk), .rst(rst), .ctl(mctl),
      .taken_in(m_taken[i]), .taken_out(m_taken[i+1]),
      .hit(m_hit[i]), .hit_owner(m_own[i])
    );
    rsd_name_cell u_rid (
      .clk(clk), .rst(rst), .ctl(rctl),
      .taken_in(r_taken[i]), .taken_out(r_taken[i+1]),
      .hit(r_hit[i]), .hit_owner(r_own[i])
    );
  end

  // keys are unique per row, so an or of the gated owners is the match
  always_comb begin
    s_own_next = '0;
    m_own_next = '0;
    r_own_next = '0;
    for (int i = 0; i < SSRC_ENTRIES; i++) s_own_next = s_own_next | s_own[i];
    for (int i = 0; i < NAME_ENTRIES; i++) begin
      m_own_next = m_own_next | m_own[i];
      r_own_next = r_own_next | r_own[i];
    end
    s_or_next = |s_hit;
    m_or_next = |m_hit;
    r_or_next = |r_hit;
  end

  always_comb begin
    sctl = '{op: OP_IDLE, key: ssrc_r, owner: owner_r};
    mctl = '{op: OP_IDLE, key: mkey_r, owner: owner_r};
    rctl = '{op: OP_IDLE, key: rkey_r, owner: owner_r};
    found_next  = 1'b0;
    owner_next  = '0;
    status_next = ST_OK;
    if (state == S_CMP) begin
      sctl.op = OP_CMP;
      mctl.op = OP_CMP;
      rctl.op = OP_CMP;
    end else if (state == S_EXEC) begin
      case (cmd_r)
        CMD_LOOKUP: begin
          if (ssrc_any) begin
            found_next = 1'b1;
            owner_next = ssrc_own;
          end else if (m_present && mid_any) begin
            found_next  = 1'b1;
            owner_next  = mid_own;
            sctl.op     = OP_WRITE;
            sctl.owner  = mid_own;
            status_next = s_full ? ST_FULL : ST_OK;
          end else if (r_present && rid_any) begin
            found_next  = 1'b1;
            owner_next  = rid_own;
            sctl.op     = OP_WRITE;
            sctl.owner  = rid_own;
            status_next = s_full ? ST_FULL : ST_OK;
          end
        end
        CMD_ADD_SSRC: begin
          if (ssrc_r != '0) begin
            if (ssrc_any) begin
              sctl.op = OP_PURGE; mctl.op = OP_PURGE; rctl.op = OP_PURGE;
              status_next = ST_SSRC;
            end else begin
              sctl.op = OP_WRITE;
              status_next = s_full ? ST_FULL : ST_OK;
            end
          end
        end
        CMD_ADD_MID: begin
          if (m_present) begin
            if (mid_any) begin
              sctl.op = OP_PURGE; mctl.op = OP_PURGE; rctl.op = OP_PURGE;
              status_next = ST_MID;
            end else begin
              mctl.op = OP_WRITE;
              status_next = m_full ? ST_FULL : ST_OK;
            end
          end
        end
        CMD_ADD_RID: begin
          if (r_present) begin
            if (rid_any) begin
              if (!has_mid_r) begin
                sctl.op = OP_PURGE; mctl.op = OP_PURGE; rctl.op = OP_PURGE;
                status_next = ST_RID;
              end
            end else begin
              rctl.op = OP_WRITE;
              status_next = r_full ? ST_FULL : ST_OK;
            end
          end
        end
        CMD_REMOVE: begin
          sctl.op = OP_PURGE; mctl.op = OP_PURGE; rctl.op = OP_PURGE;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      found       <= 1'b0;
      match_owner <= '0;
      status      <= ST_OK;
    end else begin
      done        <= 1'b0;
      found       <= 1'b0;
      match_owner <= '0;
      status      <= ST_OK;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= cmd;
            ssrc_r    <= stream_ssrc;
            owner_r   <= owner_id;
            mkey_r    <= name_key(mid_length, mid_bytes);
            rkey_r    <= name_key(rid_length, rid_bytes);
            has_mid_r <= owner_has_mid;
            state     <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          ssrc_any <= s_or_next;
          mid_any  <= m_or_next;
          rid_any  <= r_or_next;
          ssrc_own <= s_own_next;
          mid_own  <= m_own_next;
          rid_own  <= r_own_next;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          found       <= found_next;
          match_owner <= owner_next;
          status      <= status_next;
          done        <= 1'b1;
          state       <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an update step");
  a_quiet_between: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!found && match_owner == '0 && status == ST_OK))
    else $error("result ports active without strobe");
  a_owner_needs_found: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> match_owner == '0)
    else $error("owner reported without a match");
  a_take_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule
